/* hdl/tdsm_pkg.sv */
// ----------------------------------------------------------------------------
// tdsm_pkg
// Shared constants, types and fixed-point helpers of the tridiagonal block.
// ----------------------------------------------------------------------------
package tdsm_pkg;

  localparam int MAX_DIM = 64;
  localparam int ROW_W   = $clog2(MAX_DIM);
  localparam int SIZE_W  = 7;

  localparam logic [3:0] OP_SET_DIAG   = 4'd0;
  localparam logic [3:0] OP_SET_UPPER  = 4'd1;
  localparam logic [3:0] OP_SET_LOWER  = 4'd2;
  localparam logic [3:0] OP_ADD_DIAG   = 4'd3;
  localparam logic [3:0] OP_ADD_UPPER  = 4'd4;
  localparam logic [3:0] OP_ADD_LOWER  = 4'd5;
  localparam logic [3:0] OP_SCL_DIAG   = 4'd6;
  localparam logic [3:0] OP_SCL_UPPER  = 4'd7;
  localparam logic [3:0] OP_SCL_LOWER  = 4'd8;
  localparam logic [3:0] OP_LOAD_VEC   = 4'd9;
  localparam logic [3:0] OP_SOLVE      = 4'd10;
  localparam logic [3:0] OP_MULTIPLY   = 4'd11;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(Q_MAX)) r = Q_MAX;
    else if (v < 34'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qtrunc(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [47:0] s;
    logic signed [31:0] r;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    s   = adj[63:16];
    if (s > 48'(Q_MAX)) r = Q_MAX;
    else if (s < 48'(Q_MIN)) r = Q_MIN;
    else r = s[31:0];
    return r;
  endfunction

endpackage

/* hdl/tridiagonal_solve_multiply.sv */
// ----------------------------------------------------------------------------
// tridiagonal_solve_multiply
// Tridiagonal matrix store with Thomas solver and matrix-vector product.
//
//   channel | direction | fields
//   in      | input     | opcode, entry_index, operand_value
//   out     | output    | result_value, result_index, last_result, zero_pivot
//   cfg     | input     | cfg_wr_data (matrix_size)
//
// Solve factors the matrix unless it is already factored, then runs forward
// and back substitution and returns the result rows in order. Multiply
// returns one product per row.
// Synchronous reset clears band valid bits, flags and the sequencer.
// in_ready is high only while idle; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module tridiagonal_solve_multiply (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           opcode,
  input  logic [5:0]           entry_index,
  input  logic signed [31:0]   operand_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   result_value,
  output logic [5:0]           result_index,
  output logic                 last_result,
  output logic                 zero_pivot
);
  import tdsm_pkg::*;

  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_BRD  = 6'd1;
  localparam logic [5:0] ST_BOP  = 6'd2;
  localparam logic [5:0] ST_BM1  = 6'd3;
  localparam logic [5:0] ST_BM2  = 6'd4;
  localparam logic [5:0] ST_F0   = 6'd5;
  localparam logic [5:0] ST_F1   = 6'd6;
  localparam logic [5:0] ST_F2   = 6'd7;
  localparam logic [5:0] ST_F3   = 6'd8;
  localparam logic [5:0] ST_F4   = 6'd9;
  localparam logic [5:0] ST_F5   = 6'd10;
  localparam logic [5:0] ST_F6   = 6'd11;
  localparam logic [5:0] ST_F7   = 6'd12;
  localparam logic [5:0] ST_S0   = 6'd13;
  localparam logic [5:0] ST_S1   = 6'd14;
  localparam logic [5:0] ST_S2   = 6'd15;
  localparam logic [5:0] ST_S3   = 6'd16;
  localparam logic [5:0] ST_S4   = 6'd17;
  localparam logic [5:0] ST_S5   = 6'd18;
  localparam logic [5:0] ST_S6   = 6'd19;
  localparam logic [5:0] ST_B1   = 6'd20;
  localparam logic [5:0] ST_B2   = 6'd21;
  localparam logic [5:0] ST_B3   = 6'd22;
  localparam logic [5:0] ST_B4   = 6'd23;
  localparam logic [5:0] ST_O1   = 6'd24;
  localparam logic [5:0] ST_O2   = 6'd25;
  localparam logic [5:0] ST_OW   = 6'd26;
  localparam logic [5:0] ST_M1   = 6'd27;
  localparam logic [5:0] ST_M2   = 6'd28;
  localparam logic [5:0] ST_M3   = 6'd29;
  localparam logic [5:0] ST_M4   = 6'd30;
  localparam logic [5:0] ST_M5   = 6'd31;
  localparam logic [5:0] ST_M6   = 6'd32;

  logic [5:0]        state;
  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] n_rows;
  logic              factored;
  logic              zp;
  logic              is_mult;
  logic [ROW_W-1:0]  row;
  logic              row_last;
  logic [3:0]        op_r;
  logic [ROW_W-1:0]  idx_r;
  logic signed [31:0] val_r;
  logic signed [31:0] pcur;
  logic signed [31:0] wcur;
  logic signed [31:0] lower_r;
  logic signed [31:0] su_r;
  logic signed [33:0] acc;

  logic signed [31:0] diag_mem  [MAX_DIM];
  logic signed [31:0] upper_mem [MAX_DIM];
  logic signed [31:0] lower_mem [MAX_DIM];
  logic signed [31:0] su_mem    [MAX_DIM];
  logic signed [31:0] piv_mem   [MAX_DIM];
  logic signed [31:0] vec_mem   [MAX_DIM];
  logic signed [31:0] work_mem  [MAX_DIM];
  logic [MAX_DIM-1:0] diag_vld;
  logic [MAX_DIM-1:0] upper_vld;
  logic [MAX_DIM-1:0] lower_vld;

  logic signed [31:0] diag_rd, upper_rd, lower_rd, su_rd, piv_rd, vec_rd, work_rd;
  logic               diag_ok, upper_ok, lower_ok;
  logic signed [31:0] diag_v, upper_v, lower_v, band_v;

  logic [ROW_W-1:0]   baddr;
  logic [ROW_W-1:0]   vaddr;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] qm;

  logic               bwr_en;
  logic signed [31:0] bwr_data;
  logic               in_acc;
  logic signed [31:0] add_sum;
  logic signed [31:0] diff_v;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tdsm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign n_rows   = (matrix_size < SIZE_W'(2)) ? SIZE_W'(2) :
                    (matrix_size > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : matrix_size;
  assign row_last = ({1'b0, row} == n_rows - SIZE_W'(1));
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign diag_v  = diag_ok  ? diag_rd  : 32'sd0;
  assign upper_v = upper_ok ? upper_rd : 32'sd0;
  assign lower_v = lower_ok ? lower_rd : 32'sd0;

  always_comb begin
    case (op_r) inside
      OP_SET_DIAG, OP_ADD_DIAG, OP_SCL_DIAG:    band_v = diag_v;
      OP_SET_UPPER, OP_ADD_UPPER, OP_SCL_UPPER: band_v = upper_v;
      default:                                  band_v = lower_v;
    endcase
  end

  assign add_sum = sat34(34'(band_v) + 34'(val_r));

  always_comb begin
    baddr = row;
    vaddr = row;
    case (state)
      ST_BRD:                 baddr = idx_r;
      ST_F0, ST_S0:           baddr = '0;
      ST_F5, ST_F6:           baddr = row + ROW_W'(1);
      ST_S3, ST_M2:           baddr = row - ROW_W'(1);
      ST_M3:                  baddr = row;
      default:                baddr = row;
    endcase
    case (state)
      ST_M3:   vaddr = row + ROW_W'(1);
      default: vaddr = baddr;
    endcase
  end

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state)
      ST_BOP: begin mul_a = band_v;  mul_b = val_r; end
      ST_F5:  begin mul_a = lower_r; mul_b = su_r; end
      ST_S4:  begin mul_a = lower_v; mul_b = wcur; end
      ST_B2:  begin mul_a = su_rd;   mul_b = wcur; end
      ST_M2:  begin mul_a = diag_v;  mul_b = vec_rd; end
      ST_M3:  begin mul_a = (row == '0) ? 32'sd0 : lower_v; mul_b = vec_rd; end
      ST_M4:  begin mul_a = row_last ? 32'sd0 : upper_v;    mul_b = vec_rd; end
      default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    qm   <= qtrunc(prod);
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = vec_rd;
    div_req.den   = piv_rd;
    case (state)
      ST_F3: begin div_req.start = 1'b1; div_req.num = upper_v; div_req.den = pcur; end
      ST_S1: begin div_req.start = 1'b1; div_req.num = vec_rd;  div_req.den = piv_rd; end
      ST_S6: begin div_req.start = 1'b1; div_req.num = diff_v;  div_req.den = piv_rd; end
      default: div_req.start = 1'b0;
    endcase
  end

  assign diff_v = sat34(34'(vec_rd) - 34'(qm));

  always_comb begin
    bwr_en   = 1'b0;
    bwr_data = val_r;
    case (state)
      ST_BOP: begin
        if (op_r < OP_ADD_DIAG) begin
          bwr_en = 1'b1; bwr_data = val_r;
        end else if (op_r < OP_SCL_DIAG) begin
          bwr_en = 1'b1; bwr_data = add_sum;
        end
      end
      ST_BM2:  begin bwr_en = 1'b1; bwr_data = qm; end
      default: bwr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    diag_rd  <= diag_mem[baddr];
    upper_rd <= upper_mem[baddr];
    lower_rd <= lower_mem[baddr];
    su_rd    <= su_mem[baddr];
    piv_rd   <= piv_mem[baddr];
    work_rd  <= work_mem[baddr];
    vec_rd   <= vec_mem[vaddr];
    diag_ok  <= diag_vld[baddr];
    upper_ok <= upper_vld[baddr];
    lower_ok <= lower_vld[baddr];
    if (bwr_en) begin
      case (op_r) inside
        OP_SET_DIAG, OP_ADD_DIAG, OP_SCL_DIAG:    diag_mem[idx_r]  <= bwr_data;
        OP_SET_UPPER, OP_ADD_UPPER, OP_SCL_UPPER: upper_mem[idx_r] <= bwr_data;
        default:                                  lower_mem[idx_r] <= bwr_data;
      endcase
    end
    if (in_acc && opcode == OP_LOAD_VEC) vec_mem[entry_index] <= operand_value;
    if (state == ST_F1) piv_mem[0] <= diag_v;
    if (state == ST_F7) piv_mem[row + ROW_W'(1)] <= sat34(34'(diag_v) - 34'(qm));
    if (state == ST_F4 && div_rsp.done) su_mem[row] <= div_rsp.quot;
    if (state == ST_S2 && div_rsp.done) work_mem[row] <= div_rsp.quot;
    if (state == ST_B4) work_mem[row] <= sat34(34'(work_rd) - 34'(qm));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_vld  <= '0;
      upper_vld <= '0;
      lower_vld <= '0;
    end else if (bwr_en) begin
      case (op_r) inside
        OP_SET_DIAG, OP_ADD_DIAG, OP_SCL_DIAG:    diag_vld[idx_r]  <= 1'b1;
        OP_SET_UPPER, OP_ADD_UPPER, OP_SCL_UPPER: upper_vld[idx_r] <= 1'b1;
        default:                                  lower_vld[idx_r] <= 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      matrix_size <= SIZE_W'(MAX_DIM);
      factored    <= 1'b0;
      out_valid   <= 1'b0;
      zp          <= 1'b0;
      is_mult     <= 1'b0;
      row         <= '0;
    end else begin
      if (cfg_wr_en) begin
        matrix_size <= cfg_wr_data;
        factored    <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op_r  <= opcode;
            idx_r <= entry_index;
            val_r <= operand_value;
            row   <= '0;
            if (opcode <= OP_SCL_LOWER) state <= ST_BRD;
            else if (opcode == OP_SOLVE) state <= factored ? ST_S0 : ST_F0;
            else if (opcode == OP_MULTIPLY) begin
              is_mult <= 1'b1;
              state   <= ST_M1;
            end
          end
        end
        ST_BRD: state <= ST_BOP;
        ST_BOP: begin
          factored <= 1'b0;
          state    <= (op_r < OP_SCL_DIAG) ? ST_IDLE : ST_BM1;
        end
        ST_BM1: state <= ST_BM2;
        ST_BM2: state <= ST_IDLE;
        ST_F0:  state <= ST_F1;
        ST_F1: begin
          pcur  <= diag_v;
          row   <= '0;
          state <= ST_F2;
        end
        ST_F2: state <= ST_F3;
        ST_F3: begin
          lower_r <= lower_v;
          state   <= ST_F4;
        end
        ST_F4: begin
          if (div_rsp.done) begin
            su_r  <= div_rsp.quot;
            state <= ST_F5;
          end
        end
        ST_F5: state <= ST_F6;
        ST_F6: state <= ST_F7;
        ST_F7: begin
          pcur <= sat34(34'(diag_v) - 34'(qm));
          if ({1'b0, row} + SIZE_W'(2) == n_rows) begin
            factored <= 1'b1;
            row      <= '0;
            state    <= ST_S0;
          end else begin
            row   <= row + ROW_W'(1);
            state <= ST_F2;
          end
        end
        ST_S0: begin
          zp    <= 1'b0;
          row   <= '0;
          state <= ST_S1;
        end
        ST_S1: state <= ST_S2;
        ST_S2: begin
          if (div_rsp.done) begin
            wcur <= div_rsp.quot;
            zp   <= zp | div_rsp.zero;
            if (row_last) begin
              row   <= row - ROW_W'(1);
              state <= ST_B1;
            end else begin
              row   <= row + ROW_W'(1);
              state <= ST_S3;
            end
          end
        end
        ST_S3: state <= ST_S4;
        ST_S4: state <= ST_S5;
        ST_S5: state <= ST_S6;
        ST_S6: state <= ST_S2;
        ST_B1: state <= ST_B2;
        ST_B2: state <= ST_B3;
        ST_B3: state <= ST_B4;
        ST_B4: begin
          wcur <= sat34(34'(work_rd) - 34'(qm));
          if (row == '0) begin
            is_mult <= 1'b0;
            state   <= ST_O1;
          end else begin
            row   <= row - ROW_W'(1);
            state <= ST_B1;
          end
        end
        ST_O1: state <= ST_O2;
        ST_O2: begin
          result_value <= work_rd;
          result_index <= row;
          last_result  <= row_last;
          zero_pivot   <= zp;
          out_valid    <= 1'b1;
          state        <= ST_OW;
        end
        ST_OW: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              is_mult <= 1'b0;
              state   <= ST_IDLE;
            end else begin
              row   <= row + ROW_W'(1);
              state <= is_mult ? ST_M1 : ST_O1;
            end
          end
        end
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_M3;
        ST_M3: state <= ST_M4;
        ST_M4: begin
          acc   <= 34'(qm);
          state <= ST_M5;
        end
        ST_M5: begin
          acc   <= acc + 34'(qm);
          state <= ST_M6;
        end
        ST_M6: begin
          result_value <= sat34(acc + 34'(qm));
          result_index <= row;
          last_result  <= row_last;
          zero_pivot   <= 1'b0;
          out_valid    <= 1'b1;
          state        <= ST_OW;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> in_ready)
    else $error("sequencer did not return to idle after last result");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_F4 || state == ST_S2))
    else $error("divider result arrived outside a wait state");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, result_index} < n_rows))
    else $error("result row beyond matrix size");

  a_mult_no_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_mult) |-> !zero_pivot)
    else $error("zero pivot flagged on a multiply result");

endmodule

/* hdl/tdsm_div.sv */
// ----------------------------------------------------------------------------
// tdsm_div
// Q16.16 divider, one quotient bit per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
module tdsm_div (
  input  logic               clk,
  input  logic               rst,
  input  tdsm_pkg::div_req_t req,
  output tdsm_pkg::div_rsp_t rsp
);
  import tdsm_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [47:0] quo;
  logic        neg;
  logic [32:0] sh;
  logic        take;
  logic [47:0] quo_next;
  logic [31:0] num_mag;
  logic [31:0] den_mag;

  assign num_mag  = req.num[31] ? 32'(-req.num) : req.num;
  assign den_mag  = req.den[31] ? 32'(-req.den) : req.den;
  assign sh       = {rem, dvd[47]};
  assign take     = sh >= {1'b0, dsr};
  assign quo_next = {quo[46:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (busy) begin
        rem <= take ? 32'(sh - {1'b0, dsr}) : sh[31:0];
        dvd <= {dvd[46:0], 1'b0};
        quo <= quo_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.zero <= 1'b0;
          if (neg) rsp.quot <= (quo_next > 48'h8000_0000) ? Q_MIN : 32'(-quo_next[31:0]);
          else rsp.quot <= (quo_next > 48'h7FFF_FFFF) ? Q_MAX : quo_next[31:0];
        end
      end else if (req.start) begin
        if (req.den == 32'sd0) begin
          rsp.done <= 1'b1;
          rsp.zero <= 1'b1;
          rsp.quot <= req.num[31] ? Q_MIN : Q_MAX;
        end else begin
          busy <= 1'b1;
          dvd  <= {num_mag, 16'h0000};
          rem  <= 32'd0;
          quo  <= 48'd0;
          dsr  <= den_mag;
          neg  <= req.num[31] ^ req.den[31];
          cnt  <= 6'd0;
        end
      end
    end
  end

endmodule
